>>> rtl/prefix_code_table_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the prefix code table decoder
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PREFIX_CODE_TABLE_DECODER_UNIT_ASSERT_SVH
`define PREFIX_CODE_TABLE_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PCDT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PCDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pcdec_pkg.sv
// ----------------------------------------------------------------------------
// Prefix code table decoder package
// Field widths, mode and result codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package pcdec_pkg;

  localparam int SYM_W      = 8;
  localparam int IDX_IN_W   = 8;
  localparam int CODE_IN_W  = 16;
  localparam int LEN_W      = 5;
  localparam int BYTE_W     = 8;
  localparam int BIT_IDX_W  = $clog2(BYTE_W);

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic KIND_SYMBOL   = 1'b0;
  localparam logic KIND_OVERFLOW = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BIT,
    ST_SCAN,
    ST_FLUSH
  } state_t;

endpackage

>>> rtl/pcdec_table.sv
// ----------------------------------------------------------------------------
// Code table storage
// Symbol, code and length memories with one write port and one registered
// read port, plus per-slot valid bits so that unloaded slots read as unused.
// ----------------------------------------------------------------------------
module pcdec_table #(
  parameter int ENTRIES = 256,
  parameter int CODE_W  = 16,
  parameter int ADDR_W  = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [pcdec_pkg::SYM_W-1:0] wr_symbol,
  input  logic [CODE_W-1:0]           wr_code,
  input  logic [pcdec_pkg::LEN_W-1:0] wr_length,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [pcdec_pkg::SYM_W-1:0] rd_symbol,
  output logic [CODE_W-1:0]           rd_code,
  output logic [pcdec_pkg::LEN_W-1:0] rd_length
);
  import pcdec_pkg::*;

  logic [SYM_W-1:0]  sym_mem  [ENTRIES];
  logic [CODE_W-1:0] code_mem [ENTRIES];
  logic [LEN_W-1:0]  len_mem  [ENTRIES];
  logic [ENTRIES-1:0] valid_r;

  logic [SYM_W-1:0]  rd_symbol_r;
  logic [CODE_W-1:0] rd_code_r;
  logic [LEN_W-1:0]  rd_len_r;
  logic              rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sym_mem[wr_addr]  <= wr_symbol;
      code_mem[wr_addr] <= wr_code;
      len_mem[wr_addr]  <= wr_length;
    end
    rd_symbol_r <= sym_mem[rd_addr];
    rd_code_r   <= code_mem[rd_addr];
    rd_len_r    <= len_mem[rd_addr];
  end

  // A slot that was never loaded reads as length zero, which never matches.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign rd_symbol = rd_symbol_r;
  assign rd_code   = rd_code_r;
  assign rd_length = rd_valid_r ? rd_len_r : '0;

endmodule

>>> rtl/prefix_code_table_decoder_unit.sv
// ----------------------------------------------------------------------------
// Prefix code table decoder
// Loads a table of prefix codes and decodes a byte stream against it, one
// bit at a time, emitting one result item per decoded symbol or overflow.
// ----------------------------------------------------------------------------
// A load item (in_mode low) writes one table slot and leaves busy low, so
// loads can follow each other on every clock. A decode item (in_mode high)
// shifts its byte in from bit 7 down, one bit per step. After each bit the
// pending code is compared against the table by scanning the slots in index
// order through the single read port of the table memory, one slot per
// cycle, and the scan stops at the first hit. No clearing pass is needed
// after reset, because every slot carries a valid bit. Result items are
// presented for exactly one cycle with out_valid high and cannot be held off
// by the receiver; a result is kept back until the next one arrives or the
// byte ends, so that out_last can mark the final result of the byte. All but
// the final result of a byte appear while busy is high; the final one appears
// in the first cycle in which busy is low again, and it never collides with
// the results of the next byte.
// ----------------------------------------------------------------------------
`include "prefix_code_table_decoder_unit_assert.svh"

module prefix_code_table_decoder_unit #(
  parameter int TABLE_ENTRIES   = 256,
  parameter int MAX_CODE_LENGTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_mode,
  input  logic [pcdec_pkg::IDX_IN_W-1:0]    in_entry_index,
  input  logic [pcdec_pkg::SYM_W-1:0]       in_entry_symbol,
  input  logic [pcdec_pkg::CODE_IN_W-1:0]   in_entry_code,
  input  logic [pcdec_pkg::LEN_W-1:0]       in_entry_length,
  input  logic [pcdec_pkg::BYTE_W-1:0]      in_data_byte,
  output logic                              out_valid,
  output logic [pcdec_pkg::SYM_W-1:0]       out_symbol,
  output logic                              out_kind,
  output logic                              out_last
);
  import pcdec_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_ENTRIES);
  localparam int CODE_W = MAX_CODE_LENGTH;
  localparam int CNT_W  = $clog2(MAX_CODE_LENGTH + 1);
  localparam logic [IDX_IN_W:0]  ENTRIES_LIM = (IDX_IN_W + 1)'(TABLE_ENTRIES);
  localparam logic [ADDR_W-1:0]  LAST_ADDR   = ADDR_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0]   MAX_CNT     = CNT_W'(MAX_CODE_LENGTH);

  state_t state_r, state_nxt;

  // The byte being decoded is consumed from its top bit as it shifts left.
  logic [BYTE_W-1:0]    byte_r, byte_nxt;
  logic [BIT_IDX_W-1:0] bit_cnt_r, bit_cnt_nxt;

  // Pending code: a shift register that collects bits until a hit or overflow.
  logic [CODE_W-1:0] pend_bits_r, pend_bits_nxt;
  logic [CNT_W-1:0]  pend_cnt_r, pend_cnt_nxt;

  // Table scan: address issue stage and the compare stage in the cycle after it.
  logic [ADDR_W-1:0] scan_addr_r, scan_addr_nxt;
  logic              issue_r, issue_nxt;
  logic              rd_en_r, rd_en_nxt;
  logic              rd_last_r, rd_last_nxt;

  // A result is held here until it is known whether it is the last of its byte.
  logic              hold_v_r, hold_v_nxt;
  logic [SYM_W-1:0]  hold_sym_r, hold_sym_nxt;
  logic              hold_kind_r, hold_kind_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]  out_symbol_r, out_symbol_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic              out_last_r, out_last_nxt;

  logic              wr_en;
  logic [SYM_W-1:0]  rd_symbol;
  logic [CODE_W-1:0] rd_code;
  logic [LEN_W-1:0]  rd_length;
  logic [CODE_W-1:0] pend_mask;
  logic              rd_match;
  logic              scan_hit;
  logic              scan_miss;
  logic              in_range;

  assign in_range = {1'b0, in_entry_index} < ENTRIES_LIM;

  pcdec_table #(
    .ENTRIES (TABLE_ENTRIES),
    .CODE_W  (CODE_W),
    .ADDR_W  (ADDR_W)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (in_entry_index[ADDR_W-1:0]),
    .wr_symbol (in_entry_symbol),
    .wr_code   (in_entry_code[CODE_W-1:0]),
    .wr_length (in_entry_length),
    .rd_addr   (scan_addr_r),
    .rd_symbol (rd_symbol),
    .rd_code   (rd_code),
    .rd_length (rd_length)
  );

  // Only the low pend_cnt_r bits of a slot's code take part in the match.
  // The pending register never holds bits above its count.
  assign pend_mask = ~({CODE_W{1'b1}} << pend_cnt_r);
  assign rd_match  = (rd_length == LEN_W'(pend_cnt_r)) &&
                     ((rd_code & pend_mask) == pend_bits_r);
  assign scan_hit  = rd_en_r && rd_match;
  assign scan_miss = rd_en_r && rd_last_r && !rd_match;

  always_comb begin
    state_nxt      = state_r;
    byte_nxt       = byte_r;
    bit_cnt_nxt    = bit_cnt_r;
    pend_bits_nxt  = pend_bits_r;
    pend_cnt_nxt   = pend_cnt_r;
    scan_addr_nxt  = scan_addr_r;
    issue_nxt      = issue_r;
    rd_en_nxt      = 1'b0;
    rd_last_nxt    = 1'b0;
    hold_v_nxt     = hold_v_r;
    hold_sym_nxt   = hold_sym_r;
    hold_kind_nxt  = hold_kind_r;
    out_valid_nxt  = 1'b0;
    out_symbol_nxt = out_symbol_r;
    out_kind_nxt   = out_kind_r;
    out_last_nxt   = 1'b0;
    wr_en          = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_mode == MODE_LOAD) begin
            wr_en = in_range;
          end else begin
            byte_nxt    = in_data_byte;
            bit_cnt_nxt = BIT_IDX_W'(BYTE_W - 1);
            state_nxt   = ST_BIT;
          end
        end
      end

      ST_BIT: begin
        pend_bits_nxt = {pend_bits_r[CODE_W-2:0], byte_r[BYTE_W-1]};
        pend_cnt_nxt  = pend_cnt_r + 1'b1;
        byte_nxt      = byte_r << 1;
        scan_addr_nxt = '0;
        issue_nxt     = 1'b1;
        state_nxt     = ST_SCAN;
      end

      ST_SCAN: begin
        if (issue_r) begin
          rd_en_nxt   = 1'b1;
          rd_last_nxt = (scan_addr_r == LAST_ADDR);
          if (scan_addr_r == LAST_ADDR) begin
            issue_nxt = 1'b0;
          end else begin
            scan_addr_nxt = scan_addr_r + 1'b1;
          end
        end

        if (scan_hit || (scan_miss && pend_cnt_r == MAX_CNT)) begin
          // Release the previously held result, which is not the last one.
          if (hold_v_r) begin
            out_valid_nxt  = 1'b1;
            out_symbol_nxt = hold_sym_r;
            out_kind_nxt   = hold_kind_r;
          end
          hold_v_nxt    = 1'b1;
          hold_sym_nxt  = scan_hit ? rd_symbol : '0;
          hold_kind_nxt = scan_hit ? KIND_SYMBOL : KIND_OVERFLOW;
          pend_bits_nxt = '0;
          pend_cnt_nxt  = '0;
        end

        if (scan_hit || scan_miss) begin
          issue_nxt   = 1'b0;
          rd_en_nxt   = 1'b0;
          bit_cnt_nxt = bit_cnt_r - 1'b1;
          state_nxt   = (bit_cnt_r == '0) ? ST_FLUSH : ST_BIT;
        end
      end

      ST_FLUSH: begin
        if (hold_v_r) begin
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = hold_sym_r;
          out_kind_nxt   = hold_kind_r;
          out_last_nxt   = 1'b1;
          hold_v_nxt     = 1'b0;
        end
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      issue_r     <= 1'b0;
      rd_en_r     <= 1'b0;
      rd_last_r   <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      issue_r     <= issue_nxt;
      rd_en_r     <= rd_en_nxt;
      rd_last_r   <= rd_last_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r       <= byte_nxt;
    bit_cnt_r    <= bit_cnt_nxt;
    scan_addr_r  <= scan_addr_nxt;
    hold_sym_r   <= hold_sym_nxt;
    hold_kind_r  <= hold_kind_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_kind_r   <= out_kind_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_kind   = out_kind_r;
  assign out_last   = out_last_r;

  `PCDT_ASSERT_IMPLIES(a_pend_cnt_bound, 1'b1, pend_cnt_r <= MAX_CNT,
    "pending code grew past the maximum code length")
  `PCDT_ASSERT_IMPLIES(a_overflow_symbol, out_valid && out_kind == KIND_OVERFLOW,
    out_symbol == '0, "overflow result carries a nonzero symbol")
  `PCDT_ASSERT_IMPLIES(a_idle_no_hold, state_r == ST_IDLE, !hold_v_r,
    "a held result was left behind at the end of a byte")
  `PCDT_ASSERT_IMPLIES(a_read_in_scan, rd_en_r, state_r == ST_SCAN,
    "table read in flight outside a scan")
  `PCDT_ASSERT_NEXT(a_decode_start, start && !busy && in_mode == MODE_DECODE,
    state_r == ST_BIT && bit_cnt_r == BIT_IDX_W'(BYTE_W - 1),
    "decode item did not start at the first bit")

endmodule
